/* hdl/rls_pkg.sv */
`timescale 1ns / 1ps

package rls_pkg;

  // sample and level formats
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int WEIGHT_W = 16;

  // product of one sample with itself, and the halved square kept from it
  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int HALF_W = PROD_W - 3;
  // sum of the left and right halved squares of one frame
  localparam int PAIR_W = HALF_W + 1;

  // stream payload widths
  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = 2 * LEVEL_W;

  // decay weight after reset, 0.93 in Q0.16
  localparam logic [WEIGHT_W-1:0] DECAY_RESET = 16'd60948;

  // full scale of the rms level, 1/2 in Q0.16
  localparam logic [LEVEL_W:0] RMS_MAX = 17'd32768;

endpackage

/* hdl/rls_front.sv */
`timescale 1ns / 1ps

module rls_front #(
  parameter int MAX_FRAMES = 512,
  parameter int CNT_W      = 10,
  parameter int SUM_W      = 39
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rls_pkg::SAMPLE_W-1:0] left_sample,
  input  logic [rls_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                         end_of_buffer,
  input  logic                         fifo_full,
  output logic                         job_valid,
  output logic [SUM_W-1:0]             job_sum,
  output logic [CNT_W-1:0]             job_count,
  output logic                         job_ovf
);
  import rls_pkg::*;

  logic signed [SAMPLE_W-1:0] left_s;
  logic signed [SAMPLE_W-1:0] right_s;
  logic signed [PROD_W-1:0]   left_sq;
  logic signed [PROD_W-1:0]   right_sq;
  logic [PAIR_W-1:0]          pair_nxt;

  logic                       s1_valid_r;
  logic                       s1_end_r;
  logic [PAIR_W-1:0]          s1_pair_r;

  logic [SUM_W-1:0]           acc_sum_r;
  logic [CNT_W-1:0]           acc_cnt_r;
  logic                       acc_ovf_r;
  logic [SUM_W-1:0]           acc_sum_nxt;
  logic [CNT_W-1:0]           acc_cnt_nxt;
  logic                       acc_ovf_nxt;
  logic                       in_xfer;

  // hold input while the queue is full and while an end-of-buffer frame is pushed
  assign in_ready = !fifo_full && !(s1_valid_r && s1_end_r);
  assign in_xfer  = in_valid && in_ready;

  // halved squares, truncated toward zero
  assign left_s   = left_sample;
  assign right_s  = right_sample;
  assign left_sq  = left_s * left_s;
  assign right_sq = right_s * right_s;
  assign pair_nxt = {1'b0, left_sq[PROD_W-2:2]} + {1'b0, right_sq[PROD_W-2:2]};

  // square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_end_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      s1_end_r   <= in_xfer && end_of_buffer;
    end
    s1_pair_r <= pair_nxt;
  end

  // accumulate unless the frame count is saturated
  always_comb begin
    acc_sum_nxt = acc_sum_r;
    acc_cnt_nxt = acc_cnt_r;
    acc_ovf_nxt = acc_ovf_r;
    if (s1_valid_r) begin
      if (acc_cnt_r < CNT_W'(MAX_FRAMES)) begin
        acc_sum_nxt = acc_sum_r + SUM_W'(s1_pair_r);
        acc_cnt_nxt = acc_cnt_r + 1'b1;
      end else begin
        acc_ovf_nxt = 1'b1;
      end
    end
  end

  // buffer totals go to the queue on the end frame
  assign job_valid = s1_valid_r && s1_end_r;
  assign job_sum   = acc_sum_nxt;
  assign job_count = acc_cnt_nxt;
  assign job_ovf   = acc_ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_sum_r <= '0;
      acc_cnt_r <= '0;
      acc_ovf_r <= 1'b0;
    end else if (job_valid) begin
      acc_sum_r <= '0;
      acc_cnt_r <= '0;
      acc_ovf_r <= 1'b0;
    end else begin
      acc_sum_r <= acc_sum_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      acc_ovf_r <= acc_ovf_nxt;
    end
  end

  // a finished buffer always finds room in the queue
  assert property (@(posedge clk) disable iff (!rst_n) job_valid |-> !fifo_full)
    else $error("buffer totals pushed into a full queue");

  // the frame count never passes its limit
  assert property (@(posedge clk) disable iff (!rst_n)
    acc_cnt_r <= CNT_W'(MAX_FRAMES))
    else $error("frame count above limit");

endmodule

/* hdl/rls_fifo.sv */
`timescale 1ns / 1ps

module rls_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // fill level tracks the pointer distance
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CW'(DEPTH) && count_r != '0) |->
      (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with fill level");

endmodule

/* hdl/rls_back.sv */
`timescale 1ns / 1ps

module rls_back #(
  parameter int CNT_W = 10,
  parameter int SUM_W = 39
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rls_pkg::WEIGHT_W-1:0] decay_weight,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  logic [SUM_W-1:0]             job_sum,
  input  logic [CNT_W-1:0]             job_count,
  input  logic                         job_ovf,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rls_pkg::LEVEL_W-1:0]  rms_level,
  output logic [rls_pkg::LEVEL_W-1:0]  smoothed_level,
  output logic                         overlong
);
  import rls_pkg::*;

  // dividend is twice the sum, the root covers the whole quotient
  localparam int DW     = SUM_W + 1;
  localparam int ROOT_W = (DW + 1) / 2;
  localparam int XW     = 2 * ROOT_W;
  localparam int STEP_W = $clog2(DW + 1);
  localparam int CMP_W  = (ROOT_W > LEVEL_W + 1) ? ROOT_W : LEVEL_W + 1;
  localparam int BL_W   = 2 * LEVEL_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROOT,
    ST_MUL,
    ST_ADD
  } state_t;

  state_t               state_r;
  logic [STEP_W-1:0]    step_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ovf_r;
  logic [DW-1:0]        div_r;
  logic [CNT_W-1:0]     drem_r;
  logic [XW-1:0]        x_r;
  logic [ROOT_W:0]      srem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [LEVEL_W-1:0]   rms_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [2*LEVEL_W-1:0] p_old_r;
  logic [2*LEVEL_W:0]   p_new_r;

  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_rms_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 out_ovf_r;

  logic [CNT_W:0]       drem_sh;
  logic                 dfit;
  logic [ROOT_W+2:0]    srem_sh;
  logic [ROOT_W+2:0]    strial;
  logic                 sfit;
  logic [LEVEL_W-1:0]   rms_clamped;
  logic [LEVEL_W:0]     keep_weight;
  logic [BL_W-1:0]      blend;

  // one quotient bit per cycle, restoring
  assign drem_sh = {drem_r, div_r[DW-1]};
  assign dfit    = (drem_sh >= {1'b0, count_r});

  // one root bit per cycle, two radicand bits in
  assign srem_sh = {srem_r, x_r[XW-1 -: 2]};
  assign strial  = {1'b0, root_r, 2'b01};
  assign sfit    = (srem_sh >= strial);

  // rms limited to full scale; an empty buffer reads as zero
  always_comb begin
    if (count_r == '0) begin
      rms_clamped = '0;
    end else if (CMP_W'(root_r) > CMP_W'(RMS_MAX)) begin
      rms_clamped = RMS_MAX[LEVEL_W-1:0];
    end else begin
      rms_clamped = root_r[LEVEL_W-1:0];
    end
  end

  // blend with rounding half up
  assign keep_weight = {1'b1, {LEVEL_W{1'b0}}} - {1'b0, decay_weight};
  assign blend = BL_W'(p_old_r) + BL_W'(p_new_r) + BL_W'(RMS_MAX);

  assign job_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign rms_level      = out_rms_r;
  assign smoothed_level = out_level_r;
  assign overlong       = out_ovf_r;

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_ready && state_r != ST_ADD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            div_r   <= {job_sum, 1'b0};
            drem_r  <= '0;
            count_r <= job_count;
            ovf_r   <= job_ovf;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          drem_r <= dfit ? CNT_W'(drem_sh - {1'b0, count_r}) : drem_sh[CNT_W-1:0];
          div_r  <= {div_r[DW-2:0], dfit};
          if (step_r == STEP_W'(DW - 1)) begin
            step_r  <= '0;
            state_r <= ST_ROOT;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_ROOT: begin
          srem_r <= sfit ? (ROOT_W + 1)'(srem_sh - strial) : srem_sh[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], sfit};
          x_r    <= {x_r[XW-3:0], 2'b00};
          if (step_r == STEP_W'(ROOT_W - 1)) begin
            step_r  <= '0;
            state_r <= ST_MUL;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_MUL: begin
          rms_r   <= rms_clamped;
          p_old_r <= level_r * decay_weight;
          p_new_r <= rms_clamped * keep_weight;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          if (!out_valid_r || out_ready) begin
            level_r     <= blend[2*LEVEL_W-1:LEVEL_W];
            out_rms_r   <= rms_r;
            out_level_r <= blend[2*LEVEL_W-1:LEVEL_W];
            out_ovf_r   <= ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      // radicand and root start from the finished quotient
      if (state_r == ST_DIV && step_r == STEP_W'(DW - 1)) begin
        x_r    <= XW'({div_r[DW-2:0], dfit});
        srem_r <= '0;
        root_r <= '0;
      end
    end
  end

  // reported levels never exceed full scale
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_rms_r} <= RMS_MAX && {1'b0, out_level_r} <= RMS_MAX))
    else $error("level above full scale");

  // a pending result is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_level_r)))
    else $error("pending result lost");

endmodule

/* hdl/rms_level_smoother.sv */
`timescale 1ns / 1ps

// RMS level meter with exponential smoothing. Stereo Q1.15 frames stream in
// on in_*, one per clock while a buffer is being gathered; each sample is
// halved and squared into a running sum. The frame with in_tlast set closes
// the buffer, holds off the next input frame while it is pushed, and hands
// the sum and frame count to a two-entry queue. Behind the queue a shared
// sequencer works through each buffer in turn: a restoring divider gives one
// quotient bit per cycle and a digit-by-digit square root one root bit per
// cycle, then a multiply and an add blend the RMS into the smoothed level
// with the decay weight on the cfg port (Q0.16, 0.93 after reset). A result
// leaves on out_* through an output register. Besides the closing frame,
// input stalls only while the queue is full, so short buffers are paced by
// the back-end sequencer. Frames past MAX_FRAMES in one buffer are dropped
// and flagged on out_tuser with the next result.
module rms_level_smoother #(
  parameter int MAX_FRAMES = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // left_sample [15:0], right_sample [31:16]
  input  logic [rls_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // rms_level [15:0], smoothed_level [31:16]
  output logic [rls_pkg::OUT_DATA_W-1:0]   out_tdata,
  // overlong [0]
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wr_en,
  input  logic [rls_pkg::WEIGHT_W-1:0]     cfg_wr_data
);
  import rls_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = HALF_W + CNT_W;
  localparam int JOB_W = SUM_W + CNT_W + 1;

  logic [WEIGHT_W-1:0] decay_r;
  logic                fifo_full;
  logic                push_valid;
  logic [SUM_W-1:0]    push_sum;
  logic [CNT_W-1:0]    push_count;
  logic                push_ovf;
  logic                pop_valid;
  logic                pop_ready;
  logic [JOB_W-1:0]    pop_data;
  logic [LEVEL_W-1:0]  rms_level;
  logic [LEVEL_W-1:0]  smoothed_level;

  // decay weight register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
    end else if (cfg_wr_en) begin
      decay_r <= cfg_wr_data;
    end
  end

  rls_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .left_sample   (in_tdata[SAMPLE_W-1:0]),
    .right_sample  (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .end_of_buffer (in_tlast),
    .fifo_full     (fifo_full),
    .job_valid     (push_valid),
    .job_sum       (push_sum),
    .job_count     (push_count),
    .job_ovf       (push_ovf)
  );

  rls_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push_valid),
    .wr_data  ({push_ovf, push_count, push_sum}),
    .full     (fifo_full),
    .rd_en    (pop_ready),
    .rd_valid (pop_valid),
    .rd_data  (pop_data)
  );

  rls_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .decay_weight   (decay_r),
    .job_valid      (pop_valid),
    .job_ready      (pop_ready),
    .job_sum        (pop_data[SUM_W-1:0]),
    .job_count      (pop_data[SUM_W+CNT_W-1:SUM_W]),
    .job_ovf        (pop_data[JOB_W-1]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .rms_level      (rms_level),
    .smoothed_level (smoothed_level),
    .overlong       (out_tuser)
  );

  assign out_tdata = {smoothed_level, rms_level};

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_FRAMES    = 512;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PRINT_LIMIT   = 30;

  typedef struct packed {
    logic [rls_pkg::LEVEL_W-1:0] rms;
    logic [rls_pkg::LEVEL_W-1:0] smoothed;
    logic                        overlong;
  } level_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic [rls_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                             in_tlast = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rls_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                             out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b1;
  logic                             cfg_wr_en = 1'b0;
  logic [rls_pkg::WEIGHT_W-1:0]     cfg_wr_data = '0;

  // predictor state
  longint unsigned              square_total;
  int unsigned                  frame_count;
  logic [rls_pkg::LEVEL_W-1:0]  level_memory;
  logic                         frames_dropped;
  logic [rls_pkg::WEIGHT_W-1:0] decay_weight;
  level_result_t                expected_levels[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned frames_sent = 0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  bit          sender_idle = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned sink_phase = 0;
  int unsigned sink_left = 0;
  int unsigned sink_period = 4;
  int unsigned sink_duty = 0;

  rms_level_smoother #(
    .MAX_FRAMES(MAX_FRAMES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver backpressure: stall pattern re-drawn every stretch
  always @(posedge clk) begin
    int unsigned per;
    sink_phase <= sink_phase + 1;
    if (sink_left == 0) begin
      per = $urandom_range(2, 11);
      sink_left <= $urandom_range(20, 300);
      sink_period <= per;
      sink_duty <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, per - 1);
    end else begin
      sink_left <= sink_left - 1;
    end
    out_tready <= !sink_stalls || ((sink_phase % sink_period) >= sink_duty);
  end

  // (s*s)>>2 of a signed Q1.15 sample, truncated
  function automatic longint unsigned halved_square(logic [15:0] raw);
    longint sv;
    sv = longint'($signed(raw));
    return longint'(sv * sv) >> 2;
  endfunction

  // largest r with r*r <= x
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // update the level predictor with one accepted frame
  function automatic void predict_frame(logic [15:0] left_s, logic [15:0] right_s,
                                        logic last_f);
    level_result_t   res;
    longint unsigned rms_v;
    longint unsigned blend;
    if (frame_count < MAX_FRAMES) begin
      square_total = square_total + halved_square(left_s) + halved_square(right_s);
      frame_count++;
    end else begin
      frames_dropped = 1'b1;
    end
    if (!last_f) return;
    rms_v = 0;
    if (frame_count != 0) rms_v = floor_sqrt((square_total * 2) / frame_count);
    if (rms_v > 32768) rms_v = 32768;
    blend = longint'(level_memory) * decay_weight + rms_v * (65536 - decay_weight);
    level_memory = ((blend + 32768) >> 16) & 16'hFFFF;
    res.rms = rms_v[15:0];
    res.smoothed = level_memory;
    res.overlong = frames_dropped;
    expected_levels.push_back(res);
    square_total = 0;
    frame_count = 0;
    frames_dropped = 1'b0;
  endfunction

  // result checker
  always @(posedge clk) begin
    level_result_t want;
    level_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.rms = out_tdata[15:0];
      got.smoothed = out_tdata[31:16];
      got.overlong = out_tuser;
      if (expected_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
          $display("%0t: unexpected result, expected none, actual rms=%0d smoothed=%0d ovl=%0b",
                   $time, got.rms, got.smoothed, got.overlong);
      end else begin
        want = expected_levels.pop_front();
        if (want != got) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT) begin
            if (want.rms != got.rms)
              $display("%0t: rms_level expected %0d actual %0d", $time, want.rms, got.rms);
            if (want.smoothed != got.smoothed)
              $display("%0t: smoothed_level expected %0d actual %0d",
                       $time, want.smoothed, got.smoothed);
            if (want.overlong != got.overlong)
              $display("%0t: overlong expected %0b actual %0b",
                       $time, want.overlong, got.overlong);
          end
        end
      end
    end
  end

  // send one frame transaction, with random bursts and gaps
  task automatic send_frame(input logic [15:0] left_s, input logic [15:0] right_s,
                            input logic last_f);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= {right_s, left_s};
    in_tlast <= last_f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    frames_sent++;
    predict_frame(left_s, right_s, last_f);
  endtask

  // stop sending and let every pending result come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_decay(input logic [rls_pkg::WEIGHT_W-1:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    decay_weight = value;
  endtask

  // random sample, scaled down by a per-buffer loudness shift
  function automatic logic [15:0] random_sample(int unsigned quiet);
    logic signed [15:0] s;
    case ($urandom_range(0, 11))
      0: s = 16'sh8000;
      1: s = 16'sh7FFF;
      2: s = 16'sh0000;
      default: begin
        s = 16'($urandom_range(0, 16'hFFFF));
        s = s >>> quiet;
      end
    endcase
    return s;
  endfunction

  task automatic send_random_buffer(input int unsigned frames);
    int unsigned quiet;
    quiet = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
    for (int unsigned i = 0; i < frames; i++)
      send_frame(random_sample(quiet), random_sample(quiet), i == frames - 1);
  endtask

  // extremes, silence, truncation of tiny squares and short buffers at reset decay
  task automatic test_directed_frames();
    send_frame(16'h8000, 16'h8000, 1'b1);
    send_frame(16'h7FFF, 16'h7FFF, 1'b1);
    send_frame(16'h0000, 16'h0000, 1'b1);
    send_frame(16'h0001, 16'hFFFF, 1'b1);
    send_frame(16'h8000, 16'h0000, 1'b1);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'h1234, 16'hEDCB, 1'b1);
    send_frame(16'h5555, 16'hAAAA, 1'b0);
    send_frame(16'hAAAA, 16'h5555, 1'b1);
    send_frame(16'hFFFF, 16'h0001, 1'b0);
    send_frame(16'h0002, 16'hFFFE, 1'b1);
  endtask

  // smoothing at the weight extremes
  task automatic test_decay_extremes();
    logic [rls_pkg::WEIGHT_W-1:0] weights[5];
    weights = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, rls_pkg::DECAY_RESET};
    foreach (weights[i]) begin
      write_decay(weights[i]);
      send_frame(16'h8000, 16'h8000, 1'b1);
      send_frame(16'h0100, 16'hFF00, 1'b1);
    end
  endtask

  // full buffer at max scale, then one that runs past MAX_FRAMES and a short one
  task automatic test_long_buffers();
    write_decay(16'($urandom_range(0, 16'hFFFF)));
    for (int i = 0; i < MAX_FRAMES; i++)
      send_frame(16'h8000, 16'h8000, i == MAX_FRAMES - 1);
    send_random_buffer(MAX_FRAMES + 3);
    send_random_buffer(2);
  endtask

  // random buffer lengths and content, several weights per run
  task automatic test_random_buffers();
    logic [rls_pkg::WEIGHT_W-1:0] weights[6];
    int unsigned phase_start;
    int unsigned pick;
    weights = '{16'hFFFF, 16'd0, 16'($urandom_range(0, 16'hFFFF)), 16'h8000,
                16'($urandom_range(0, 16'hFFFF)), rls_pkg::DECAY_RESET};
    foreach (weights[p]) begin
      write_decay(weights[p]);
      sender_idle = (p != 2);
      sink_stalls = (p != 4);
      phase_start = frames_sent;
      while (frames_sent - phase_start < 90) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send_random_buffer($urandom_range(1, 8));
        else if (pick < 95) send_random_buffer($urandom_range(9, 40));
        else send_random_buffer($urandom_range(41, 120));
      end
    end
    sender_idle = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    square_total = 0;
    frame_count = 0;
    level_memory = '0;
    frames_dropped = 1'b0;
    decay_weight = rls_pkg::DECAY_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_decay_extremes();
    test_long_buffers();
    test_random_buffers();
    drain_results();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/rls_pkg.sv
hdl/rls_front.sv
hdl/rls_fifo.sv
hdl/rls_back.sv
hdl/rms_level_smoother.sv
sim/tb_top.sv
